### design/acpu_pkg.sv
package acpu_pkg;

   localparam int WORD_W = 8;

   // Command codes carried by an input item.
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_STEP  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Configuration register indexes (bit 2 of the byte address).
   localparam logic CSR_IDX_START = 1'b0;
   localparam logic CSR_IDX_HALT  = 1'b1;

   // Reset values.
   localparam logic [WORD_W-1:0] START_RESET = 8'h28;
   localparam logic [WORD_W-1:0] HALT_RESET  = 8'h00;
   localparam logic [WORD_W-1:0] ACC_RESET   = 8'h10;
   localparam logic [WORD_W-1:0] OUT_RESET   = 8'h00;

   // Opcodes.
   localparam logic [WORD_W-1:0] OP_LOAD_IMM  = 8'h00;
   localparam logic [WORD_W-1:0] OP_LOAD_DIR  = 8'h40;
   localparam logic [WORD_W-1:0] OP_LOAD_IND  = 8'hC0;
   localparam logic [WORD_W-1:0] OP_ADD_IMM   = 8'h20;
   localparam logic [WORD_W-1:0] OP_ADD_DIR   = 8'h60;
   localparam logic [WORD_W-1:0] OP_ADD_IND   = 8'hE0;
   localparam logic [WORD_W-1:0] OP_SUB_IMM   = 8'h21;
   localparam logic [WORD_W-1:0] OP_SUB_DIR   = 8'h61;
   localparam logic [WORD_W-1:0] OP_SUB_IND   = 8'hE1;
   localparam logic [WORD_W-1:0] OP_NAND_IMM  = 8'h22;
   localparam logic [WORD_W-1:0] OP_NAND_DIR  = 8'h62;
   localparam logic [WORD_W-1:0] OP_NAND_IND  = 8'hE2;
   localparam logic [WORD_W-1:0] OP_STORE_DIR = 8'h48;
   localparam logic [WORD_W-1:0] OP_STORE_IND = 8'hC8;
   localparam logic [WORD_W-1:0] OP_IN_DIR    = 8'h49;
   localparam logic [WORD_W-1:0] OP_IN_IND    = 8'hC9;
   localparam logic [WORD_W-1:0] OP_OUT_DIR   = 8'h41;
   localparam logic [WORD_W-1:0] OP_OUT_IND   = 8'hC1;
   localparam logic [WORD_W-1:0] OP_JUMP      = 8'h10;
   localparam logic [WORD_W-1:0] OP_BRN       = 8'h11;
   localparam logic [WORD_W-1:0] OP_BRZ       = 8'h12;

   typedef enum logic [3:0] {
      K_LOAD, K_ADD, K_SUB, K_NAND, K_STORE, K_IN, K_OUT,
      K_JUMP, K_BRN, K_BRZ, K_BAD
   } kind_type;

   typedef enum logic [1:0] {
      M_IMM, M_DIR, M_IND
   } mode_type;

   typedef struct packed {
      kind_type kind;
      mode_type mode;
   } op_info_type;

   typedef enum logic [2:0] {
      S_IDLE, S_ISSUE, S_OPCODE, S_OPERAND, S_POINTER, S_VALUE, S_RDBYTE, S_FINISH
   } state_type;

   function automatic op_info_type decode_op(input logic [WORD_W-1:0] op);
      op_info_type info;
      info.kind = K_BAD;
      info.mode = M_IMM;
      case (op)
         OP_LOAD_IMM: begin info.kind = K_LOAD; info.mode = M_IMM; end
         OP_LOAD_DIR: begin info.kind = K_LOAD; info.mode = M_DIR; end
         OP_LOAD_IND: begin info.kind = K_LOAD; info.mode = M_IND; end
         OP_ADD_IMM: begin info.kind = K_ADD; info.mode = M_IMM; end
         OP_ADD_DIR: begin info.kind = K_ADD; info.mode = M_DIR; end
         OP_ADD_IND: begin info.kind = K_ADD; info.mode = M_IND; end
         OP_SUB_IMM: begin info.kind = K_SUB; info.mode = M_IMM; end
         OP_SUB_DIR: begin info.kind = K_SUB; info.mode = M_DIR; end
         OP_SUB_IND: begin info.kind = K_SUB; info.mode = M_IND; end
         OP_NAND_IMM: begin info.kind = K_NAND; info.mode = M_IMM; end
         OP_NAND_DIR: begin info.kind = K_NAND; info.mode = M_DIR; end
         OP_NAND_IND: begin info.kind = K_NAND; info.mode = M_IND; end
         OP_STORE_DIR: begin info.kind = K_STORE; info.mode = M_DIR; end
         OP_STORE_IND: begin info.kind = K_STORE; info.mode = M_IND; end
         OP_IN_DIR: begin info.kind = K_IN; info.mode = M_DIR; end
         OP_IN_IND: begin info.kind = K_IN; info.mode = M_IND; end
         OP_OUT_DIR: begin info.kind = K_OUT; info.mode = M_DIR; end
         OP_OUT_IND: begin info.kind = K_OUT; info.mode = M_IND; end
         OP_JUMP: begin info.kind = K_JUMP; end
         OP_BRN: begin info.kind = K_BRN; end
         OP_BRZ: begin info.kind = K_BRZ; end
         default: begin info.kind = K_BAD; end
      endcase
      return info;
   endfunction

   // Accumulator update for LOAD, ADD, SUB and NAND; sums wrap at 8 bits.
   function automatic logic [WORD_W-1:0] alu(input kind_type kind,
                                              input logic [WORD_W-1:0] acc,
                                              input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] res;
      case (kind)
         K_LOAD: res = v;
         K_ADD: res = acc + v;
         K_SUB: res = acc - v;
         K_NAND: res = ~(acc & v);
         default: res = acc;
      endcase
      return res;
   endfunction

endpackage

### design/acpu_req_if.sv
interface acpu_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] address;
   logic [7:0] data_byte;
   logic [7:0] input_value;

   modport source (output valid, command, address, data_byte, input_value, input ready);
   modport sink (input valid, command, address, data_byte, input_value, output ready);
endinterface

### design/acpu_rsp_if.sv
interface acpu_rsp_if;
   logic              valid;
   logic              ready;
   logic [7:0]        program_counter;
   logic signed [7:0] accumulator_value;
   logic [7:0]        read_byte;
   logic              output_valid;
   logic [7:0]        output_value;
   logic              halted;
   logic              bad_opcode;

   modport source (output valid, program_counter, accumulator_value, read_byte,
                   output_valid, output_value, halted, bad_opcode, input ready);
   modport sink (input valid, program_counter, accumulator_value, read_byte,
                 output_valid, output_value, halted, bad_opcode, output ready);
endinterface

### design/acpu_ram.sv
module acpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### design/accumulator_cpu_step.sv
// Eight-bit accumulator processor, driven one command item at a time.
// The req channel carries an item: a command (write a memory byte, read a
// memory byte, or execute one instruction), an address and data byte for the
// memory commands, and the byte that an IN instruction takes. Every item gives
// exactly one item on the rsp channel: PC, accumulator, the byte read, the OUT
// flag and output register, halted and bad_opcode.
// The machine state lives in one single-port memory with a registered read,
// so an instruction is a sequence of fetch, operand, pointer and value
// accesses through that port: branches and immediate operands need only the
// first two, direct operands add the value read, indirect ones the pointer
// read too (STORE and IN write instead of reading the value). A new item is
// accepted only after the last one has finished.
// The result is registered; a new item is accepted while an earlier result
// still waits, and only the finish of the next item waits on rsp ready.
// Reset (synchronous, active high) loads PC with the start address (40),
// the accumulator with 0x10, clears the output register and the handshakes.
// Memory is not cleared. The APB port holds start_address at 0x0 (a write
// also loads PC) and halt_address at 0x4; write them only while idle.
module accumulator_cpu_step #(
   parameter int MEMORY_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   acpu_req_if.sink          req_chan,
   acpu_rsp_if.source        rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   import acpu_pkg::*;

   localparam int AW = $clog2(MEMORY_DEPTH);

   // Architectural state and configuration.
   logic [WORD_W-1:0] pc_ff, pc_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] outreg_ff, outreg_in;
   logic [WORD_W-1:0] start_ff, start_in;
   logic [WORD_W-1:0] halt_ff, halt_in;

   // Sequencer and the item being worked on.
   state_type         state_ff, state_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic [WORD_W-1:0] addr_ff, addr_in;
   logic [WORD_W-1:0] data_ff, data_in;
   logic [WORD_W-1:0] inval_ff, inval_in;
   op_info_type       info_ff, info_in;
   logic [WORD_W-1:0] rd_ff, rd_in;
   logic              outv_ff, outv_in;
   logic              bad_ff, bad_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_pc_ff, rsp_acc_ff, rsp_rd_ff, rsp_out_ff;
   logic              rsp_outv_ff, rsp_halt_ff, rsp_bad_ff;
   logic              rsp_load;

   // Memory port.
   logic [WORD_W-1:0] mem_addr;
   logic              mem_we;
   logic [WORD_W-1:0] mem_wdata;
   logic [WORD_W-1:0] mem_rdata;
   logic [AW-1:0]     mem_index;

   logic req_accept;
   logic csr_write;

   // Every memory address wraps modulo the memory depth. The table is built
   // at elaboration and is a plain 256-entry lookup on the address.
   logic [AW-1:0] wrap_tab [256];
   for (genvar g = 0; g < 256; g++) begin : g_wrap
      assign wrap_tab[g] = AW'(g % MEMORY_DEPTH);
   end

   assign mem_index = wrap_tab[mem_addr];

   acpu_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEMORY_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_index),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign req_accept = req_chan.valid && req_chan.ready;

   // Configuration port: no wait states.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_HALT) ? {24'd0, halt_ff} : {24'd0, start_ff};

   // The sequencer. Each state that issues a memory access sees the data in
   // the next state, so the states line up with the memory accesses of an
   // instruction: opcode fetch, operand fetch, pointer read, value read.
   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      acc_in    = acc_ff;
      outreg_in = outreg_ff;
      cmd_in    = cmd_ff;
      addr_in   = addr_ff;
      data_in   = data_ff;
      inval_in  = inval_ff;
      info_in   = info_ff;
      rd_in     = rd_ff;
      outv_in   = outv_ff;
      bad_in    = bad_ff;
      mem_addr  = pc_ff;
      mem_we    = 1'b0;
      mem_wdata = acc_ff;
      rsp_load  = 1'b0;
      req_chan.ready = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               cmd_in   = req_chan.command;
               addr_in  = req_chan.address;
               data_in  = req_chan.data_byte;
               inval_in = req_chan.input_value;
               rd_in    = '0;
               outv_in  = 1'b0;
               bad_in   = 1'b0;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            case (cmd_ff)
               CMD_WRITE: begin
                  mem_addr  = addr_ff;
                  mem_we    = 1'b1;
                  mem_wdata = data_ff;
                  state_in  = S_FINISH;
               end
               CMD_READ: begin
                  mem_addr = addr_ff;
                  state_in = S_RDBYTE;
               end
               CMD_STEP: begin
                  mem_addr = pc_ff;
                  pc_in    = pc_ff + 8'd1;
                  state_in = S_OPCODE;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_RDBYTE: begin
            rd_in    = mem_rdata;
            state_in = S_FINISH;
         end
         S_OPCODE: begin
            // The byte after the opcode is read ahead for every instruction;
            // an undefined opcode simply ignores it.
            info_in  = decode_op(mem_rdata);
            mem_addr = pc_ff;
            if (info_in.kind == K_BAD) begin
               bad_in   = 1'b1;
               state_in = S_FINISH;
            end else begin
               state_in = S_OPERAND;
            end
         end
         S_OPERAND: begin
            state_in = S_FINISH;
            case (info_ff.kind)
               K_JUMP: begin
                  pc_in = mem_rdata;
               end
               K_BRN: begin
                  pc_in = acc_ff[WORD_W-1] ? mem_rdata : pc_ff + 8'd1;
               end
               K_BRZ: begin
                  pc_in = (acc_ff == '0) ? mem_rdata : pc_ff + 8'd1;
               end
               K_LOAD, K_ADD, K_SUB, K_NAND: begin
                  pc_in    = pc_ff + 8'd1;
                  mem_addr = mem_rdata;
                  if (info_ff.mode == M_IMM) begin
                     acc_in = alu(info_ff.kind, acc_ff, mem_rdata);
                  end else if (info_ff.mode == M_DIR) begin
                     state_in = S_VALUE;
                  end else begin
                     state_in = S_POINTER;
                  end
               end
               K_STORE, K_IN, K_OUT: begin
                  pc_in    = pc_ff + 8'd1;
                  mem_addr = mem_rdata;
                  if (info_ff.mode == M_IND) begin
                     state_in = S_POINTER;
                  end else if (info_ff.kind == K_OUT) begin
                     state_in = S_VALUE;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = (info_ff.kind == K_IN) ? inval_ff : acc_ff;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_POINTER: begin
            mem_addr = mem_rdata;
            if (info_ff.kind == K_STORE || info_ff.kind == K_IN) begin
               mem_we    = 1'b1;
               mem_wdata = (info_ff.kind == K_IN) ? inval_ff : acc_ff;
               state_in  = S_FINISH;
            end else begin
               state_in = S_VALUE;
            end
         end
         S_VALUE: begin
            if (info_ff.kind == K_OUT) begin
               outreg_in = mem_rdata;
               outv_in   = 1'b1;
            end else begin
               acc_in = alu(info_ff.kind, acc_ff, mem_rdata);
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // The result register is free, or is emptied in this same cycle.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Writing the start address also moves PC there.
      if (csr_write && csr_paddr[2] == CSR_IDX_START) begin
         pc_in = csr_pwdata[WORD_W-1:0];
      end
   end

   always_comb begin
      start_in = start_ff;
      halt_in  = halt_ff;
      if (csr_write) begin
         if (csr_paddr[2] == CSR_IDX_START) begin
            start_in = csr_pwdata[WORD_W-1:0];
         end else begin
            halt_in = csr_pwdata[WORD_W-1:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= START_RESET;
         acc_ff       <= ACC_RESET;
         outreg_ff    <= OUT_RESET;
         start_ff     <= START_RESET;
         halt_ff      <= HALT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         acc_ff       <= acc_in;
         outreg_ff    <= outreg_in;
         start_ff     <= start_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      addr_ff  <= addr_in;
      data_ff  <= data_in;
      inval_ff <= inval_in;
      info_ff  <= info_in;
      rd_ff    <= rd_in;
      outv_ff  <= outv_in;
      bad_ff   <= bad_in;
      if (rsp_load) begin
         rsp_pc_ff   <= pc_ff;
         rsp_acc_ff  <= acc_ff;
         rsp_rd_ff   <= rd_ff;
         rsp_out_ff  <= outreg_ff;
         rsp_outv_ff <= outv_ff;
         rsp_halt_ff <= (cmd_ff == CMD_STEP) && (pc_ff == halt_ff);
         rsp_bad_ff  <= bad_ff;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.program_counter   = rsp_pc_ff;
   assign rsp_chan.accumulator_value = $signed(rsp_acc_ff);
   assign rsp_chan.read_byte         = rsp_rd_ff;
   assign rsp_chan.output_valid      = rsp_outv_ff;
   assign rsp_chan.output_value      = rsp_out_ff;
   assign rsp_chan.halted            = rsp_halt_ff;
   assign rsp_chan.bad_opcode        = rsp_bad_ff;

   // Memory writes come only from the write command or the last access of a
   // STORE or IN.
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_ISSUE || state_ff == S_OPERAND || state_ff == S_POINTER))
      else $error("memory write outside a write state");

   // An accepted item always starts at the dispatch state.
   a_accept_issue: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == S_ISSUE)
      else $error("accepted item did not reach dispatch");

   // A finished item with a free result slot is presented the next cycle.
   a_finish_present: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && (!rsp_valid_ff || rsp_chan.ready))
      |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished item not presented");

   // The accumulator only moves where an operand value is consumed.
   a_acc_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_OPERAND && state_ff != S_VALUE) |=> $stable(acc_ff))
      else $error("accumulator changed outside an operand state");

endmodule
